/* sv/sfcd_pkg.sv */
// Shared types, constants and the CRC-8 step for the sensor frame CRC decoder.
`default_nettype none
package sfcd_pkg;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [15:0] ID_MASK     = 16'h083F;
   localparam logic [15:0] ID_MATCH    = 16'h0807;
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUMI_SPAN   = 14'd10000;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_CRC_ERROR   = 2'd1,
      STATUS_ID_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      POS_W0_HIGH = 3'd0,
      POS_W0_LOW  = 3'd1,
      POS_W0_CRC  = 3'd2,
      POS_W1_HIGH = 3'd3,
      POS_W1_LOW  = 3'd4,
      POS_W1_CRC  = 3'd5
   } pos_type;

   typedef enum logic {
      MODE_MEASURE  = 1'b0,
      MODE_IDENTITY = 1'b1
   } mode_type;

   typedef struct packed {
      status_type  status;
      logic        identity;
      logic [15:0] raw_first;
      logic [15:0] raw_second;
   } frame_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* sv/sfcd_if.sv */
// Request, response and control register channels of the sensor frame CRC decoder.
`default_nettype none
interface sfcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;
   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [15:0]        raw_first;
   logic [15:0]        raw_second;
   logic signed [14:0] temperature;
   logic [13:0]        humidity;
   modport source (output valid, output status, output raw_first, output raw_second,
                   output temperature, output humidity, input ready);
   modport sink (input valid, input status, input raw_first, input raw_second,
                 input temperature, input humidity, output ready);
endinterface

interface sfcd_csr_if;
   logic valid;
   logic ready;
   logic frame_mode;
   modport source (output valid, output frame_mode, input ready);
   modport sink (input valid, input frame_mode, output ready);
endinterface
`default_nettype wire

/* sv/sensor_frame_crc_decoder.sv */
// Sensor frame decoder: running CRC-8 check per word and conversion of finished frames.
// One request byte is accepted per cycle whenever the frame stage is free or moving on.
// After the last byte of a frame is accepted, one register stage holds the checked frame
// and the next holds the scaled values that go out on the response channel.
// Synchronous reset clears the byte position, the error flag, the mode register, both
// valid flags and sets the running CRC to its start value; no clearing pass is needed.
`default_nettype none
module sensor_frame_crc_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   sfcd_req_if.sink   req_chan,
   sfcd_rsp_if.source rsp_chan,
   sfcd_csr_if.sink   csr_chan
);
   import sfcd_pkg::*;

   mode_type    mode_ff;
   pos_type     pos_ff, pos_in, pos_cur;
   logic [7:0]  crc_ff, crc_in, crc_cur, crc_next;
   logic        err_ff, err_in, err_cur, err_word;
   logic [7:0]  high_ff, high_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;
   logic        emit;
   frame_type   frame;

   logic        accept, a_load, rsp_load;
   logic        a_valid_ff;
   frame_type   a_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [15:0]        rsp_first_ff, rsp_second_ff;
   logic signed [14:0] rsp_temp_ff, rsp_temp_in;
   logic [13:0]        rsp_humi_ff, rsp_humi_in;
   logic [30:0]        temp_prod;
   logic [29:0]        humi_prod;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MEASURE;
      end else if (csr_chan.valid) begin
         mode_ff <= mode_type'(csr_chan.frame_mode);
      end
   end

   assign rsp_load       = !rsp_valid_ff || rsp_chan.ready;
   assign a_load         = !a_valid_ff || rsp_load;
   assign req_chan.ready = a_load;
   assign accept         = req_chan.valid && a_load;

   // A start byte drops any partial frame and begins a new one.
   always_comb begin
      pos_cur  = req_chan.frame_start ? POS_W0_HIGH : pos_ff;
      crc_cur  = req_chan.frame_start ? CRC_INIT : crc_ff;
      err_cur  = req_chan.frame_start ? 1'b0 : err_ff;
      crc_next = crc_feed(crc_cur, req_chan.rx_byte);
      err_word = err_cur || (crc_cur != req_chan.rx_byte);
   end

   // Next state of the frame tracker.
   always_comb begin
      pos_in    = pos_cur;
      crc_in    = crc_cur;
      err_in    = err_cur;
      high_in   = high_ff;
      first_in  = first_ff;
      second_in = second_ff;
      unique case (pos_cur)
         POS_W0_HIGH, POS_W1_HIGH: begin
            high_in = req_chan.rx_byte;
            crc_in  = crc_next;
            pos_in  = pos_type'(pos_cur + 3'd1);
         end
         POS_W0_LOW: begin
            first_in = {high_ff, req_chan.rx_byte};
            crc_in   = crc_next;
            pos_in   = POS_W0_CRC;
         end
         POS_W1_LOW: begin
            second_in = {high_ff, req_chan.rx_byte};
            crc_in    = crc_next;
            pos_in    = POS_W1_CRC;
         end
         POS_W0_CRC: begin
            crc_in = CRC_INIT;
            if (mode_ff == MODE_MEASURE) begin
               pos_in = POS_W1_HIGH;
               err_in = err_word;
            end else begin
               pos_in = POS_W0_HIGH;
               err_in = 1'b0;
            end
         end
         POS_W1_CRC: begin
            crc_in = CRC_INIT;
            pos_in = POS_W0_HIGH;
            err_in = 1'b0;
         end
         default: begin
            high_in = req_chan.rx_byte;
            crc_in  = crc_next;
            pos_in  = POS_W0_LOW;
         end
      endcase
   end

   // Frame result at the last byte of a frame.
   always_comb begin
      emit             = 1'b0;
      frame.identity   = 1'b0;
      frame.raw_first  = first_ff;
      frame.raw_second = second_ff;
      frame.status     = err_word ? STATUS_CRC_ERROR : STATUS_OK;
      unique case (pos_cur)
         POS_W0_CRC: begin
            if (mode_ff == MODE_IDENTITY) begin
               emit             = 1'b1;
               frame.identity   = 1'b1;
               frame.raw_second = '0;
               if (!err_word && ((first_ff & ID_MASK) != ID_MATCH)) begin
                  frame.status = STATUS_ID_MISMATCH;
               end
            end
         end
         POS_W1_CRC: begin
            emit = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_W0_HIGH;
         crc_ff <= CRC_INIT;
         err_ff <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         high_ff   <= high_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         a_ff <= frame;
      end
   end

   always_comb begin
      temp_prod   = 31'(TEMP_SPAN) * 31'(a_ff.raw_first);
      humi_prod   = 30'(HUMI_SPAN) * 30'(a_ff.raw_second);
      rsp_temp_in = a_ff.identity ? '0 : signed'(temp_prod[30:16] - TEMP_OFFSET);
      rsp_humi_in = a_ff.identity ? '0 : humi_prod[29:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && a_valid_ff) begin
         rsp_status_ff <= a_ff.status;
         rsp_first_ff  <= a_ff.raw_first;
         rsp_second_ff <= a_ff.raw_second;
         rsp_temp_ff   <= rsp_temp_in;
         rsp_humi_ff   <= rsp_humi_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.raw_first   = rsp_first_ff;
   assign rsp_chan.raw_second  = rsp_second_ff;
   assign rsp_chan.temperature = rsp_temp_ff;
   assign rsp_chan.humidity    = rsp_humi_ff;

endmodule
`default_nettype wire

/* sv/sfcd_checker.sv */
// Port checker for the sensor frame CRC decoder and its bind to the top level.
`default_nettype none
module sfcd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic [15:0]        rsp_raw_first,
   input wire logic [15:0]        rsp_raw_second,
   input wire logic signed [14:0] rsp_temperature,
   input wire logic [13:0]        rsp_humidity
);
   import sfcd_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_raw_first) && $stable(rsp_raw_second)
         && $stable(rsp_temperature) && $stable(rsp_humidity))
      else $error("Stalled response changed.");

   a_mismatch_is_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ID_MISMATCH)
         |-> (rsp_raw_second == 16'd0) && (rsp_temperature == 15'sd0)
            && (rsp_humidity == 14'd0))
      else $error("Identity mismatch carries measurement values.");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity <= 14'd9999) && (rsp_temperature >= -15'sd4500)
         && (rsp_status != 2'd3))
      else $error("Response field out of range.");

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_raw_first   (rsp_chan.raw_first),
   .rsp_raw_second  (rsp_chan.raw_second),
   .rsp_temperature (rsp_chan.temperature),
   .rsp_humidity    (rsp_chan.humidity)
);
`default_nettype wire

/* tb/sv/sfcd_frame_checker.sv */
// Frame checker: predicts decoded sensor frames from accepted request bytes and compares responses.
`timescale 1ns / 100ps
module sfcd_frame_checker (
   input  logic clock,
   input  logic reset,
   sfcd_req_if  req_chan,
   sfcd_rsp_if  rsp_chan,
   sfcd_csr_if  csr_chan,
   output int   fail_count,
   output int   pending,
   output int   frames_checked
);
   import sfcd_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      status_type  status;
      logic [15:0] raw_first;
      logic [15:0] raw_second;
      logic [14:0] temperature;
      logic [13:0] humidity;
   } frame_result_type;

   frame_result_type expected_frames[$];

   mode_type    cur_mode;
   pos_type     byte_pos;
   logic [7:0]  crc_acc;
   logic [7:0]  high_hold;
   logic [15:0] word0_hold;
   logic [15:0] word1_hold;
   logic        crc_bad;

   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[7] ^ data[i]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [14:0] temp_centi(input logic [15:0] raw);
      logic [31:0] p;
      p = 32'(TEMP_SPAN) * 32'(raw);
      p = (p >> 16) - 32'(TEMP_OFFSET);
      return p[14:0];
   endfunction

   function automatic logic [13:0] humi_centi(input logic [15:0] raw);
      logic [31:0] p;
      p = 32'(HUMI_SPAN) * 32'(raw);
      return p[29:16];
   endfunction

   task report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("%0t ns  frame mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   task decode_byte(input logic [7:0] data, input logic restart);
      frame_result_type r;
      if (restart) begin
         byte_pos = POS_W0_HIGH;
         crc_acc  = CRC_INIT;
         crc_bad  = 1'b0;
      end
      case (byte_pos)
         POS_W0_HIGH: begin
            high_hold = data;
            crc_acc   = crc8_step(crc_acc, data);
            byte_pos  = POS_W0_LOW;
         end
         POS_W1_HIGH: begin
            high_hold = data;
            crc_acc   = crc8_step(crc_acc, data);
            byte_pos  = POS_W1_LOW;
         end
         POS_W0_LOW: begin
            crc_acc    = crc8_step(crc_acc, data);
            word0_hold = {high_hold, data};
            byte_pos   = POS_W0_CRC;
         end
         POS_W1_LOW: begin
            crc_acc    = crc8_step(crc_acc, data);
            word1_hold = {high_hold, data};
            byte_pos   = POS_W1_CRC;
         end
         default: begin
            if (crc_acc != data) begin
               crc_bad = 1'b1;
            end
            crc_acc = CRC_INIT;
            if (byte_pos == POS_W0_CRC && cur_mode == MODE_MEASURE) begin
               byte_pos = POS_W1_HIGH;
            end else begin
               r.raw_first = word0_hold;
               if (byte_pos == POS_W0_CRC) begin
                  if (crc_bad) begin
                     r.status = STATUS_CRC_ERROR;
                  end else if ((word0_hold & ID_MASK) != ID_MATCH) begin
                     r.status = STATUS_ID_MISMATCH;
                  end else begin
                     r.status = STATUS_OK;
                  end
                  r.raw_second  = '0;
                  r.temperature = '0;
                  r.humidity    = '0;
               end else begin
                  if (crc_bad) begin
                     r.status = STATUS_CRC_ERROR;
                  end else begin
                     r.status = STATUS_OK;
                  end
                  r.raw_second  = word1_hold;
                  r.temperature = temp_centi(word0_hold);
                  r.humidity    = humi_centi(word1_hold);
               end
               expected_frames.push_back(r);
               byte_pos = POS_W0_HIGH;
               crc_bad  = 1'b0;
            end
         end
      endcase
   endtask

   task check_response();
      frame_result_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("response with no frame outstanding, raw_first %h",
                                   rsp_chan.raw_first));
         return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if (rsp_chan.status !== want.status) begin
         report_mismatch($sformatf("status %0d, expected %0d", rsp_chan.status, want.status));
      end
      if (rsp_chan.raw_first !== want.raw_first) begin
         report_mismatch($sformatf("raw_first %h, expected %h", rsp_chan.raw_first,
                                   want.raw_first));
      end
      if (rsp_chan.raw_second !== want.raw_second) begin
         report_mismatch($sformatf("raw_second %h, expected %h", rsp_chan.raw_second,
                                   want.raw_second));
      end
      if (rsp_chan.temperature !== want.temperature) begin
         report_mismatch($sformatf("temperature %0d, expected %0d (raw %h)",
                                   $signed(rsp_chan.temperature),
                                   $signed(want.temperature), want.raw_first));
      end
      if (rsp_chan.humidity !== want.humidity) begin
         report_mismatch($sformatf("humidity %0d, expected %0d (raw %h)", rsp_chan.humidity,
                                   want.humidity, want.raw_second));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_mode       = MODE_MEASURE;
         byte_pos       = POS_W0_HIGH;
         crc_acc        = CRC_INIT;
         high_hold      = '0;
         word0_hold     = '0;
         word1_hold     = '0;
         crc_bad        = 1'b0;
         fail_count     = 0;
         frames_checked = 0;
         expected_frames.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_response();
         end
         if (csr_chan.valid && csr_chan.ready) begin
            cur_mode = mode_type'(csr_chan.frame_mode);
         end
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(req_chan.rx_byte, req_chan.frame_start);
         end
      end
      pending = expected_frames.size();
   end

endmodule

/* tb/sv/sensor_frame_crc_decoder_tb.sv */
// Testbench top for the sensor frame CRC decoder: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module sensor_frame_crc_decoder_tb;
   import sfcd_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int NUM_PHASES      = 10;
   localparam int PHASE_BYTES     = 175;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES = 400000;

   logic clock;
   logic reset;
   int   failures;
   int   frames_pending;
   int   frames_seen;
   int   bytes_sent;
   int   mode_writes;
   bit   quiet_mode;
   bit   hold_req;
   bit   need_resync;
   mode_type   tb_mode;
   logic [7:0] carry_bytes[$];

   sfcd_req_if req_chan();
   sfcd_rsp_if rsp_chan();
   sfcd_csr_if csr_chan();

   sensor_frame_crc_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   sfcd_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .fail_count     (failures),
      .pending        (frames_pending),
      .frames_checked (frames_seen)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("Timeout after %0d cycles with %0d frames outstanding.", WATCHDOG_CYCLES,
               frames_pending);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_chan.ready <= quiet_mode || ($urandom_range(99) >= 24);
         end
      end
   end

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc_feed(crc_feed(CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_identity();
      if ($urandom_range(1) == 1) begin
         return (16'($urandom) & ~ID_MASK) | ID_MATCH;
      end
      return pick_raw();
   endfunction

   task automatic push_byte(input logic [7:0] data, input logic restart);
      int gap;
      gap = 0;
      if (!quiet_mode && $urandom_range(99) < 14) begin
         gap = $urandom_range(3, 1);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= data;
      req_chan.frame_start <= restart;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [15:0] w, input bit corrupt, input logic restart);
      logic [7:0] c;
      c = word_crc(w);
      if (corrupt) begin
         c = c ^ 8'($urandom_range(255, 1));
      end
      push_byte(w[15:8], restart);
      push_byte(w[7:0], 1'b0);
      push_byte(c, 1'b0);
   endtask

   task automatic send_random_frame();
      logic restart;
      restart     = need_resync || ($urandom_range(1) == 1);
      need_resync = 1'b0;
      if (tb_mode == MODE_IDENTITY) begin
         send_word(pick_identity(), $urandom_range(99) < 12, restart);
      end else begin
         send_word(pick_raw(), $urandom_range(99) < 12, restart);
         send_word(pick_raw(), $urandom_range(99) < 12, 1'b0);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(5, 1);
      repeat (n) push_byte(8'($urandom), $urandom_range(3) == 0);
      need_resync = 1'b1;
   endtask

   // The rest of this frame is sent after the next register write.
   task automatic start_split_frame();
      logic [15:0] w;
      int keep;
      for (int i = 0; i < 2; i++) begin
         w = pick_raw();
         carry_bytes.push_back(w[15:8]);
         carry_bytes.push_back(w[7:0]);
         carry_bytes.push_back(word_crc(w));
      end
      keep = $urandom_range(5, 1);
      for (int i = 0; i < keep; i++) begin
         push_byte(carry_bytes.pop_front(), i == 0);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frames_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      @(negedge clock);
      csr_chan.valid      <= 1'b1;
      csr_chan.frame_mode <= m;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      tb_mode = m;
      mode_writes++;
   endtask

   initial begin
      int target;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.rx_byte     = '0;
      req_chan.frame_start = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.frame_mode  = 1'b0;
      quiet_mode           = 1'b0;
      hold_req             = 1'b0;
      need_resync          = 1'b0;
      bytes_sent           = 0;
      mode_writes          = 0;
      tb_mode              = MODE_MEASURE;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(MODE_MEASURE);
      send_word(16'h0000, 1'b0, 1'b1);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'h0000, 1'b1, 1'b0);
      settle();
      write_mode(MODE_IDENTITY);
      send_word(ID_MATCH, 1'b0, 1'b0);
      send_word(16'hFFFF, 1'b0, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
      push_byte(8'hA5, 1'b0);
      send_word(16'hFFC7, 1'b0, 1'b1);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         if (ph < 6) begin
            write_mode(mode_type'((ph + 1) % 2));
         end else begin
            write_mode(mode_type'($urandom_range(1)));
         end
         while (carry_bytes.size() != 0) begin
            push_byte(carry_bytes.pop_front(), 1'b0);
            need_resync = 1'b1;
         end
         @(negedge clock);
         req_chan.valid <= 1'b0;
         quiet_mode = (ph == 2);
         if (ph == 4) begin
            hold_req = 1'b1;
         end
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if ($urandom_range(99) < 8) begin
               send_noise();
            end else begin
               send_random_frame();
            end
         end
         if (ph < NUM_PHASES - 1 && $urandom_range(99) < 60) begin
            start_split_frame();
         end
      end

      settle();
      $display("Run covered %0d request bytes over %0d register writes in both frame modes.",
               bytes_sent, mode_writes);
      $display("Compared %0d frames, with CRC errors, identity mismatches and resyncs mixed in.",
               frames_seen);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/sfcd_pkg.sv
sv/sfcd_if.sv
sv/sensor_frame_crc_decoder.sv
sv/sfcd_checker.sv
tb/sv/sfcd_frame_checker.sv
tb/sv/sensor_frame_crc_decoder_tb.sv
